>>> sv/rb_pkg.sv
// shared types and constants for the relative bearing pipeline
`timescale 1ns / 1ps

package rb_pkg;

   localparam int CORDIC_WIDTH = 64;
   localparam int ACC_WIDTH    = 32;
   localparam int ATAN_ENTRIES = 24;
   localparam int SCALE_BASE   = 60;

   localparam logic [ACC_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

   // arctangent of 2^-i as a 32-bit binary angle, rounded to nearest
   localparam logic [ACC_WIDTH-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic                    zero;
      logic [CORDIC_WIDTH-1:0] x;
      logic [CORDIC_WIDTH-1:0] y;
      logic [ACC_WIDTH-1:0]    z;
   } cordic_type;

endpackage

>>> sv/rb_prep.sv
// offset computation, scaling and half-plane fold ahead of the cordic
`timescale 1ns / 1ps

module rb_prep #(
   parameter int POS_WIDTH   = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [POS_WIDTH-1:0]   focal_x,
   input  logic [POS_WIDTH-1:0]   focal_y,
   input  logic [ANGLE_WIDTH-1:0] focal_heading,
   input  logic [POS_WIDTH-1:0]   neighbor_x,
   input  logic [POS_WIDTH-1:0]   neighbor_y,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rb_pkg::cordic_type     out_data,
   output logic [ANGLE_WIDTH-1:0] out_heading
);
   import rb_pkg::*;

   localparam int DIFF_WIDTH = POS_WIDTH + 1;
   localparam int SCALE      = SCALE_BASE - POS_WIDTH;

   logic                   a_valid_ff;
   logic [DIFF_WIDTH-1:0]  a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   logic [ANGLE_WIDTH-1:0] a_head_ff;
   logic                   a_ready;

   logic                   b_valid_ff;
   cordic_type             b_data_ff, b_data_in;
   logic [ANGLE_WIDTH-1:0] b_head_ff;
   logic                   b_ready;

   logic [CORDIC_WIDTH-1:0] x_scaled, y_scaled;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_dx_in = {neighbor_x[POS_WIDTH-1], neighbor_x} - {focal_x[POS_WIDTH-1], focal_x};
      a_dy_in = {neighbor_y[POS_WIDTH-1], neighbor_y} - {focal_y[POS_WIDTH-1], focal_y};
   end

   always_comb begin
      x_scaled = {{(CORDIC_WIDTH-DIFF_WIDTH){a_dx_ff[DIFF_WIDTH-1]}}, a_dx_ff} << SCALE;
      y_scaled = {{(CORDIC_WIDTH-DIFF_WIDTH){a_dy_ff[DIFF_WIDTH-1]}}, a_dy_ff} << SCALE;
      b_data_in.zero = (a_dx_ff == '0) && (a_dy_ff == '0);
      // left half plane: turn the vector by a half turn
      if (a_dx_ff[DIFF_WIDTH-1]) begin
         b_data_in.x = CORDIC_WIDTH'(-x_scaled);
         b_data_in.y = CORDIC_WIDTH'(-y_scaled);
         b_data_in.z = HALF_TURN;
      end else begin
         b_data_in.x = x_scaled;
         b_data_in.y = y_scaled;
         b_data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_head_ff <= focal_heading;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
         b_head_ff <= a_head_ff;
      end
   end

   assign out_valid   = b_valid_ff;
   assign out_data    = b_data_ff;
   assign out_heading = b_head_ff;

endmodule

>>> sv/rb_cordic_stage.sv
// one registered cordic vectoring iteration
`timescale 1ns / 1ps

module rb_cordic_stage #(
   parameter int STAGE       = 0,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rb_pkg::cordic_type     in_data,
   input  logic [ANGLE_WIDTH-1:0] in_heading,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rb_pkg::cordic_type     out_data,
   output logic [ANGLE_WIDTH-1:0] out_heading
);
   import rb_pkg::*;

   logic                    valid_ff;
   cordic_type              data_ff, data_in;
   logic [ANGLE_WIDTH-1:0]  head_ff;
   logic [CORDIC_WIDTH-1:0] xs, ys;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs = CORDIC_WIDTH'($signed(in_data.x) >>> STAGE);
      ys = CORDIC_WIDTH'($signed(in_data.y) >>> STAGE);
      data_in.zero = in_data.zero;
      // rotate toward the x axis according to the sign of y
      if (!in_data.y[CORDIC_WIDTH-1]) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN_TABLE[STAGE];
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN_TABLE[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
         head_ff <= in_heading;
      end
   end

   assign out_valid   = valid_ff;
   assign out_data    = data_ff;
   assign out_heading = head_ff;

endmodule

>>> sv/rb_finish.sv
// angle rounding and heading subtraction, output register
`timescale 1ns / 1ps

module rb_finish #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rb_pkg::cordic_type     in_data,
   input  logic [ANGLE_WIDTH-1:0] in_heading,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ANGLE_WIDTH-1:0] out_bearing
);
   import rb_pkg::*;

   localparam logic [ACC_WIDTH-1:0] ROUND_BIT = ACC_WIDTH'(1) << (ACC_WIDTH - 1 - ANGLE_WIDTH);

   logic                   valid_ff;
   logic [ANGLE_WIDTH-1:0] bearing_ff, bearing_in;
   logic [ACC_WIDTH-1:0]   z_round;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // coincident positions give angle zero
      z_round    = (in_data.zero ? '0 : in_data.z) + ROUND_BIT;
      bearing_in = z_round[ACC_WIDTH-1 -: ANGLE_WIDTH] - in_heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         bearing_ff <= bearing_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_bearing = bearing_ff;

endmodule

>>> sv/relative_bearing.sv
// relative bearing top level: prep, cordic stage chain, finish
// a request passes the prep offset and fold registers, one register per cordic stage, then the finish register
// throughput: one transaction per cycle while rsp_stall is low, one cordic iteration per register stage
// each stage holds its item only while the next one is full and stalled,
// so bubbles close up and requests keep flowing behind a waiting response
// reset: synchronous, clears all valid bits; the pipeline comes up empty
`timescale 1ns / 1ps

module relative_bearing #(
   parameter int POS_WIDTH     = 32,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [POS_WIDTH-1:0]   req_focal_x,
   input  logic signed [POS_WIDTH-1:0]   req_focal_y,
   input  logic signed [ANGLE_WIDTH-1:0] req_focal_heading,
   input  logic signed [POS_WIDTH-1:0]   req_neighbor_x,
   input  logic signed [POS_WIDTH-1:0]   req_neighbor_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0] rsp_bearing
);
   import rb_pkg::*;

   localparam int NUM_STAGES = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

   logic                   stg_valid [NUM_STAGES+1];
   logic                   stg_ready [NUM_STAGES+1];
   cordic_type             stg_data  [NUM_STAGES+1];
   logic [ANGLE_WIDTH-1:0] stg_head  [NUM_STAGES+1];
   logic                   prep_ready;
   logic [ANGLE_WIDTH-1:0] bearing;

   assign req_stall = !prep_ready;

   rb_prep #(
      .POS_WIDTH   (POS_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (prep_ready),
      .focal_x       (req_focal_x),
      .focal_y       (req_focal_y),
      .focal_heading (req_focal_heading),
      .neighbor_x    (req_neighbor_x),
      .neighbor_y    (req_neighbor_y),
      .out_valid     (stg_valid[0]),
      .out_ready     (stg_ready[0]),
      .out_data      (stg_data[0]),
      .out_heading   (stg_head[0])
   );

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cordic
      rb_cordic_stage #(
         .STAGE       (i),
         .ANGLE_WIDTH (ANGLE_WIDTH)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (stg_valid[i]),
         .in_ready    (stg_ready[i]),
         .in_data     (stg_data[i]),
         .in_heading  (stg_head[i]),
         .out_valid   (stg_valid[i+1]),
         .out_ready   (stg_ready[i+1]),
         .out_data    (stg_data[i+1]),
         .out_heading (stg_head[i+1])
      );
   end

   rb_finish #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stg_valid[NUM_STAGES]),
      .in_ready    (stg_ready[NUM_STAGES]),
      .in_data     (stg_data[NUM_STAGES]),
      .in_heading  (stg_head[NUM_STAGES]),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_bearing (bearing)
   );

   assign rsp_bearing = bearing;

endmodule

>>> sv/rb_checker.sv
// port-level checks for the relative bearing pipeline, bound to the top level
`timescale 1ns / 1ps

module rb_checker #(
   parameter int ANGLE_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [ANGLE_WIDTH-1:0] rsp_bearing
);

   logic [7:0] inflight_ff, inflight_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff + 8'(req_take) - 8'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // nothing comes out of an empty pipeline
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 8'd0)
      else $error("response without an outstanding transaction");

   // an empty pipeline always takes a request
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == 8'd0 |-> !req_stall)
      else $error("request stalled while pipeline is empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bearing))
      else $error("stalled response changed");

endmodule

bind relative_bearing rb_checker #(
   .ANGLE_WIDTH (ANGLE_WIDTH)
) u_rb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_bearing (rsp_bearing)
);

>>> dv/tb.sv
// self-checking testbench for the relative bearing pipeline
`timescale 1ns / 1ps

module tb;
   import rb_pkg::*;

   localparam int POS_W       = 32;
   localparam int ANG_W       = 16;
   localparam int STAGES      = 16;
   localparam int SHIFT       = SCALE_BASE - POS_W;
   localparam int N_RANDOM    = 800;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 250;
   localparam int QUIET_TAIL  = 120;
   localparam int SHOW_MAX    = 30;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
   localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

   typedef struct {
      logic signed [POS_W-1:0] fx;
      logic signed [POS_W-1:0] fy;
      logic signed [ANG_W-1:0] hd;
      logic signed [POS_W-1:0] nx;
      logic signed [POS_W-1:0] ny;
      bit                      drain_before;
      bit                      hold_after;
   } query_type;

   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic signed [POS_W-1:0] req_focal_x       = '0;
   logic signed [POS_W-1:0] req_focal_y       = '0;
   logic signed [ANG_W-1:0] req_focal_heading = '0;
   logic signed [POS_W-1:0] req_neighbor_x    = '0;
   logic signed [POS_W-1:0] req_neighbor_y    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic signed [ANG_W-1:0] rsp_bearing;

   query_type               pending_q[$];
   logic signed [ANG_W-1:0] bearing_q[$];
   int                      fail_count  = 0;
   int                      cycle_count = 0;
   bit                      req_taken   = 1'b0;
   bit                      hold_go     = 1'b0;
   bit                      holding     = 1'b0;
   bit                      quiet       = 1'b0;

   relative_bearing #(
      .POS_WIDTH    (POS_W),
      .ANGLE_WIDTH  (ANG_W),
      .CORDIC_STAGES(STAGES)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_focal_x      (req_focal_x),
      .req_focal_y      (req_focal_y),
      .req_focal_heading(req_focal_heading),
      .req_neighbor_x   (req_neighbor_x),
      .req_neighbor_y   (req_neighbor_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bearing      (rsp_bearing)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // atan2 of the offset by cordic vectoring, rounded, minus the heading
   function automatic logic signed [ANG_W-1:0] predict_bearing(input query_type q);
      longint          dx;
      longint          dy;
      longint          x;
      longint          y;
      longint          xs;
      longint          ys;
      logic [ACC_WIDTH-1:0] z;
      logic [ACC_WIDTH-1:0] zr;
      logic [ANG_W-1:0]     ang;
      int              i;
      dx = longint'(q.nx) - longint'(q.fx);
      dy = longint'(q.ny) - longint'(q.fy);
      z  = '0;
      if (dx != 0 || dy != 0) begin
         x = dx <<< SHIFT;
         y = dy <<< SHIFT;
         // left half plane: flip the vector, start from a half turn
         if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
         end
         for (i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_TABLE[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_TABLE[i];
            end
         end
      end
      zr  = z + (ACC_WIDTH'(1) << (ACC_WIDTH - 1 - ANG_W));
      ang = zr[ACC_WIDTH-1 -: ANG_W];
      return ang - q.hd;
   endfunction

   task automatic report_mismatch(input string what, input logic signed [ANG_W-1:0] got,
                                  input logic signed [ANG_W-1:0] want);
      fail_count++;
      if (fail_count <= SHOW_MAX)
         $display("mismatch @%0d: %s bearing got %0d want %0d", cycle_count, what, got, want);
   endtask

   task automatic add_query(input logic signed [POS_W-1:0] fx, input logic signed [POS_W-1:0] fy,
                            input logic signed [ANG_W-1:0] hd, input logic signed [POS_W-1:0] nx,
                            input logic signed [POS_W-1:0] ny);
      query_type q;
      q.fx = fx;
      q.fy = fy;
      q.hd = hd;
      q.nx = nx;
      q.ny = ny;
      q.drain_before = 1'b0;
      q.hold_after   = 1'b0;
      pending_q.push_back(q);
   endtask

   function automatic logic signed [POS_W-1:0] edge_pos();
      case ($urandom_range(0, 4))
         0:       return POS_MIN;
         1:       return POS_MAX;
         2:       return '0;
         3:       return -1;
         default: return 1;
      endcase
   endfunction

   function automatic query_type random_query();
      query_type               q;
      logic signed [POS_W-1:0] ox;
      logic signed [POS_W-1:0] oy;
      int                      kind;
      kind = $urandom_range(0, 19);
      q.fx = $urandom();
      q.fy = $urandom();
      q.hd = ANG_W'($urandom());
      q.drain_before = 1'b0;
      q.hold_after   = 1'b0;
      ox = $signed(POS_W'($urandom())) >>> $urandom_range(0, POS_W - 1);
      oy = $signed(POS_W'($urandom())) >>> $urandom_range(0, POS_W - 1);
      if (kind < 6) begin
         q.nx = $urandom();
         q.ny = $urandom();
      end else if (kind < 14) begin
         // neighbor near the focal robot
         q.nx = q.fx + ox;
         q.ny = q.fy + oy;
      end else if (kind == 14) begin
         q.nx = q.fx;
         q.ny = q.fy;
      end else if (kind < 17) begin
         // offset along an axis
         if ($urandom_range(0, 1)) begin
            q.nx = q.fx;
            q.ny = q.fy + oy;
         end else begin
            q.nx = q.fx + ox;
            q.ny = q.fy;
         end
      end else begin
         q.fx = edge_pos();
         q.fy = edge_pos();
         q.nx = edge_pos();
         q.ny = edge_pos();
         if ($urandom_range(0, 1))
            q.hd = $urandom_range(0, 1) ? ANG_MAX : ANG_MIN;
      end
      return q;
   endfunction

   // driver: one transaction offered at a time, changes only at the falling edge
   always @(negedge clock) begin
      int gap_left;
      query_type q;
      quiet <= (pending_q.size() < QUIET_TAIL);
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_q.size() != 0 &&
                      !(pending_q[0].drain_before && bearing_q.size() != 0)) begin
            q = pending_q.pop_front();
            req_valid         <= 1'b1;
            req_focal_x       <= q.fx;
            req_focal_y       <= q.fy;
            req_focal_heading <= q.hd;
            req_neighbor_x    <= q.nx;
            req_neighbor_y    <= q.ny;
            if (q.hold_after)
               hold_go <= 1'b1;
            if (!quiet && !holding && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random bursts plus one long hold-off to back up the pipe
   always @(negedge clock) begin
      int stall_left;
      int hold_left;
      bit hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
         if (hold_left == 0)
            holding <= 1'b0;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
         holding <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 17) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      query_type               q;
      logic signed [ANG_W-1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         cycle_count++;
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (bearing_q.size() == 0) begin
               report_mismatch("unexpected transaction,", rsp_bearing, '0);
            end else begin
               want = bearing_q.pop_front();
               if (rsp_bearing !== want)
                  report_mismatch("field", rsp_bearing, want);
            end
         end
         if (req_valid && !req_stall) begin
            q.fx = req_focal_x;
            q.fy = req_focal_y;
            q.hd = req_focal_heading;
            q.nx = req_neighbor_x;
            q.ny = req_neighbor_y;
            bearing_q.push_back(predict_bearing(q));
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      query_type q;
      int        n;
      // coincident positions: bearing is minus the heading
      add_query(0, 0, 0, 0, 0);
      add_query(123, -45, ANG_MAX, 123, -45);
      add_query(POS_MIN, POS_MAX, ANG_MIN, POS_MIN, POS_MAX);
      // axis directions
      add_query(0, 0, 0, 100, 0);
      add_query(0, 0, 0, 0, 7);
      add_query(0, 0, 0, 0, -7);
      // exact half turn, plain and with a half-turn heading
      add_query(0, 0, 0, -5, 0);
      add_query(10, 3, ANG_MIN, -20, 3);
      // left half plane, then one diagonal in the right half plane
      add_query(0, 0, 0, -3, 4);
      add_query(0, 0, 1, -3, -4);
      add_query(0, 0, -1, 1, 1);
      // widest offsets, then a unit offset and a coincident corner
      add_query(POS_MIN, 0, 0, POS_MAX, 0);
      add_query(POS_MAX, 0, 0, POS_MIN, 0);
      add_query(0, POS_MIN, ANG_MAX, 0, POS_MAX);
      add_query(0, POS_MAX, ANG_MIN, 0, POS_MIN);
      add_query(POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX);
      add_query(POS_MAX, POS_MAX, 0, POS_MIN, POS_MIN);
      add_query(POS_MAX, POS_MIN, 16384, POS_MIN, POS_MAX);
      add_query(0, POS_MAX, -16384, -1, POS_MIN);
      add_query(-1, -1, ANG_MAX, 0, 0);
      add_query(POS_MAX, POS_MAX, ANG_MAX, POS_MAX, POS_MAX);
      for (n = 0; n < N_RANDOM; n++) begin
         q = random_query();
         q.hold_after   = (n == 150);
         q.drain_before = (n == 450);
         pending_q.push_back(q);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_q.size() != 0 || (req_valid && !req_taken))
         @(negedge clock);
      while (bearing_q.size() != 0)
         @(negedge clock);
      repeat (STAGES + 24) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
